// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Sizes, operation and status codes, state encoding and cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;

    // port field widths
    localparam int OPCODE_W = 2;
    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    // internal count width: holds 0 .. CAPACITY
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam key_t   INVALID_KEY = '1;
    localparam count_t FULL_COUNT  = COUNT_W'(CAPACITY);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // command broadcast along the row of cells
    typedef struct packed {
        logic cmp_en;   // capture compare flags against the search key
        logic ins;      // open a gap at the rank and write the search key
        logic rem;      // close the gap at the rank
    } cell_cmd_t;

    // take the key bits that the table uses
    function automatic key_t key_of(logic [KEY_IN_W-1:0] k);
        return KEY_BITS'(k);
    endfunction

endpackage

`default_nettype wire

// File: hdl/skt_in_if.sv
// ----------------------------------------------------------------------------
// skt_in_if: request channel of the sorted key table
// Valid/ready handshake carrying one operation and one key.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_in_if import skt_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);

endinterface

`default_nettype wire

// File: hdl/skt_out_if.sv
// ----------------------------------------------------------------------------
// skt_out_if: response channel of the sorted key table
// Valid/ready handshake carrying the result of one operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_out_if import skt_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    entry_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output found, output position,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input found, input position,
                    input entry_count, input status, output ready);

endinterface

`default_nettype wire

// File: hdl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key row
// Holds one key, compares it with the search key and shifts with neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell import skt_pkg::*; (
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire key_t      search_key,
    input  wire logic      occupied,    // slot lies below the held count
    input  wire logic      lt_left,     // left neighbour holds a smaller key
    input  wire key_t      key_left,
    input  wire key_t      key_right,
    output logic           lt,          // this slot holds a smaller key
    output logic           eq,          // this slot holds the search key
    output key_t           key
);

    key_t key_reg;
    key_t key_next;
    logic lt_reg;
    logic lt_next;
    logic eq_reg;
    logic eq_next;

    // compare flags, captured once per operation
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (cmd.cmp_en)
        begin
            lt_next = occupied && (key_reg < search_key);
            eq_next = occupied && (key_reg == search_key);
        end
    end

    // shift up on insert, down on remove, for slots at or above the rank
    always_comb
    begin
        key_next = key_reg;
        if (cmd.ins && !lt_reg)
        begin
            key_next = lt_left ? search_key : key_left;
        end
        else if (cmd.rem && !lt_reg)
        begin
            key_next = key_right;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign key = key_reg;

endmodule

`default_nettype wire

// File: hdl/skt_row.sv
// ----------------------------------------------------------------------------
// skt_row: chain of key cells
// Links the cells to their neighbours, encodes the rank and the hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_row import skt_pkg::*; (
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire key_t      search_key,
    input  wire count_t    count,
    output count_t         rank,
    output logic           hit
);

    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    key_t                keys [CAPACITY];
    logic [CAPACITY+1:0] lt_ext;

    // build the chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic occupied;
        logic lt_left;
        key_t key_left;
        key_t key_right;

        assign occupied = (COUNT_W'(i) < count);

        if (i == 0)
        begin : g_first
            assign lt_left  = 1'b1;
            assign key_left = search_key;
        end
        else
        begin : g_inner
            assign lt_left  = lt_vec[i-1];
            assign key_left = keys[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign key_right = keys[i];
        end
        else
        begin : g_body
            assign key_right = keys[i+1];
        end

        skt_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .search_key (search_key),
            .occupied   (occupied),
            .lt_left    (lt_left),
            .key_left   (key_left),
            .key_right  (key_right),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i]),
            .key        (keys[i])
        );
    end

    // the less-than flags form a thermometer; the rank is where it ends
    assign lt_ext = {1'b0, lt_vec, 1'b1};

    always_comb
    begin
        rank = '0;
        for (int i = 0; i <= CAPACITY; i++)
        begin
            if (lt_ext[i] && !lt_ext[i+1])
            begin
                rank = rank | COUNT_W'(i);
            end
        end
    end

    assign hit = |eq_vec;

endmodule

`default_nettype wire

// File: hdl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top: ordered key set on a chain of compare-and-shift cells
// Each request is accepted in the idle state, then passes the compare step and
// the update step in the cell row; its response is registered at the update.
// A new request is taken only after the update step; a stalled response holds it.
// Reset empties the table; key slots are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_top import skt_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    skt_in_if.sink    req,
    skt_out_if.source rsp
);

    state_t    state_reg;
    state_t    state_next;
    count_t    count_reg;
    count_t    count_next;
    opcode_t   op_reg;
    key_t      key_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      found_reg;
    count_t    pos_reg;
    count_t    cnt_out_reg;
    status_t   status_reg;

    cell_cmd_t cmd;
    count_t    rank;
    logic      hit;
    logic      out_free;
    logic      load;
    logic      invalid;
    logic      full;
    logic      found_c;
    count_t    pos_c;
    status_t   status_c;

    assign out_free = !out_valid_reg || rsp.ready;
    assign invalid  = (key_reg == INVALID_KEY);
    assign full     = (count_reg >= FULL_COUNT);
    assign load     = (state_reg == S_UPD) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req.valid) state_next = S_CMP;
            S_CMP:   state_next = S_UPD;
            S_UPD:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // controls for the row
    always_comb
    begin
        cmd        = '0;
        cmd.cmp_en = (state_reg == S_CMP);
        if (load && !invalid)
        begin
            cmd.ins = (op_reg == OP_INSERT) && !hit && !full;
            cmd.rem = (op_reg == OP_REMOVE) && hit;
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    // result of the operation and the new count
    always_comb
    begin
        found_c    = 1'b0;
        pos_c      = count_reg;
        status_c   = ST_OK;
        count_next = count_reg;
        if (op_reg == OP_CLEAR)
        begin
            pos_c      = '0;
            count_next = '0;
        end
        else if (invalid)
        begin
            status_c = ST_INVALID;
        end
        else
        begin
            unique case (op_reg)
                OP_LOOKUP:
                begin
                    found_c = hit;
                    pos_c   = hit ? rank : count_reg;
                end
                OP_INSERT:
                begin
                    found_c = hit;
                    pos_c   = rank;
                    if (!hit && full)
                    begin
                        status_c = ST_FULL;
                    end
                    else if (!hit)
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                OP_REMOVE:
                begin
                    found_c = hit;
                    pos_c   = hit ? rank : count_reg;
                    if (hit)
                    begin
                        count_next = count_reg - count_t'(1);
                    end
                end
                default:
                begin
                    found_c = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                count_reg <= count_next;
            end
        end
    end

    // hold the request and the response payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= opcode_t'(req.opcode);
            key_reg <= key_of(req.key);
        end
        if (load)
        begin
            found_reg   <= found_c;
            pos_reg     <= pos_c;
            cnt_out_reg <= count_next;
            status_reg  <= status_c;
        end
    end

    skt_row u_row (
        .clk        (clk),
        .cmd        (cmd),
        .search_key (key_reg),
        .count      (count_reg),
        .rank       (rank),
        .hit        (hit)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.position    = POS_W'(pos_reg);
    assign rsp.entry_count = POS_W'(cnt_out_reg);
    assign rsp.status      = status_reg;

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count beyond capacity");

    // count moves only when an update completes
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(count_reg))
        else $error("held count changed outside an update");

    // a refused insert reports a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> cnt_out_reg == FULL_COUNT)
        else $error("table-full status with spare room");

    // a found key never comes with an error status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> status_reg == ST_OK)
        else $error("found flag with error status");

    // the row is never shifted both ways at once
    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.rem))
        else $error("insert and remove shift together");

endmodule

`default_nettype wire

// File: tb/sorted_key_table_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top_tb: self-checking bench for the sorted key table
// Drives lookup, insert, remove and clear requests, first from a short table
// of directed cases and then in random episodes that fill, overfill and churn
// the table. A shadow copy of the ordered key set predicts each response that
// has no typed expectation; each response transfer is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_top_tb;

    import skt_pkg::*;

    localparam int LONG_HOLD    = 240;
    localparam int MAX_REPORTED = 40;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
        status_t            status;
    } table_rsp_t;

    typedef struct {
        opcode_t    op;
        key_t       key;
        bit         typed;
        table_rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    skt_in_if  req_if ();
    skt_out_if rsp_if ();

    sorted_key_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow of the ordered key set
    key_t       shadow_keys [CAPACITY];
    int         shadow_count;

    table_rsp_t pending_results [$];
    dir_row_t   directed_rows [$];

    // item on the request channel: typed expectation, where the row has one
    bit         row_typed;
    table_rsp_t row_want;

    bit         src_idle_on;
    bit         sink_idle_on;
    bit         long_hold_req;
    int         fail_count;
    int         rsp_index;

    always #1 clk = ~clk;

    initial
    begin
        #500000;
        $display("simulation failed");
        $finish;
    end

    function automatic table_rsp_t mk_rsp(bit found, int pos, int cnt, status_t st);
        table_rsp_t r;
        r.found       = found;
        r.position    = POS_W'(pos);
        r.entry_count = POS_W'(cnt);
        r.status      = st;
        return r;
    endfunction

    // apply one operation to the shadow set and return the response it yields
    function automatic table_rsp_t apply_table_op(opcode_t op, logic [KEY_IN_W-1:0] raw_key);
        table_rsp_t r;
        key_t       k;
        int         rank;
        bit         hit;
        r = mk_rsp(1'b0, 0, 0, ST_OK);
        k = raw_key[KEY_BITS-1:0];
        if (op == OP_CLEAR)
        begin
            shadow_count = 0;
        end
        else if (k == INVALID_KEY)
        begin
            r.status   = ST_INVALID;
            r.position = POS_W'(shadow_count);
        end
        else
        begin
            // lower bound: first held key not below k
            rank = 0;
            while (rank < shadow_count && shadow_keys[rank] < k)
                rank++;
            hit = (rank < shadow_count) && (shadow_keys[rank] == k);
            case (op)
                OP_LOOKUP:
                begin
                    r.found    = hit;
                    r.position = POS_W'(hit ? rank : shadow_count);
                end
                OP_INSERT:
                begin
                    r.position = POS_W'(rank);
                    if (hit)
                        r.found = 1'b1;
                    else if (shadow_count >= CAPACITY)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = shadow_count; i > rank; i--)
                            shadow_keys[i] = shadow_keys[i-1];
                        shadow_keys[rank] = k;
                        shadow_count++;
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        r.found    = 1'b1;
                        r.position = POS_W'(rank);
                        for (int i = rank; i + 1 < shadow_count; i++)
                            shadow_keys[i] = shadow_keys[i+1];
                        shadow_count--;
                    end
                    else
                        r.position = POS_W'(shadow_count);
                end
            endcase
        end
        r.entry_count = POS_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("mismatch on response %0d: %s got %0d expected %0d",
                     rsp_index, what, got, want);
    endtask

    // record request transfers, then check response transfers in order
    always @(posedge clk)
    begin
        table_rsp_t pred;
        table_rsp_t want;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                pred = apply_table_op(opcode_t'(req_if.opcode), req_if.key);
                pending_results.push_back(row_typed ? row_want : pred);
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("response with nothing pending, entry_count",
                                    rsp_if.entry_count, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_if.found !== want.found)
                        report_mismatch("found", rsp_if.found, want.found);
                    if (rsp_if.position !== want.position)
                        report_mismatch("position", rsp_if.position, want.position);
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch("entry_count", rsp_if.entry_count, want.entry_count);
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", rsp_if.status, want.status);
                end
                rsp_index++;
            end
        end
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int sink_wait;
        sink_wait = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                sink_wait = LONG_HOLD;
            end
            else if (sink_wait == 0 && sink_idle_on && $urandom_range(0, 5) == 0)
                sink_wait = $urandom_range(1, 13);
            if (sink_wait > 0)
            begin
                rsp_if.ready = 1'b0;
                sink_wait--;
            end
            else
                rsp_if.ready = 1'b1;
        end
    end

    // offer one request from a falling edge and hold it until its transfer
    task automatic send_op(opcode_t op, key_t k, bit typed, table_rsp_t want);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            req_if.valid  = 1'b0;
            req_if.opcode = OPCODE_W'($urandom);
            req_if.key    = $urandom;
            repeat (gap) @(negedge clk);
        end
        req_if.valid  = 1'b1;
        req_if.opcode = op;
        req_if.key    = k;
        row_typed     = typed;
        row_want      = want;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic add_row(opcode_t op, key_t k, bit typed,
                           bit found, int pos, int cnt, status_t st);
        dir_row_t row;
        row.op    = op;
        row.key   = k;
        row.typed = typed;
        row.want  = mk_rsp(found, pos, cnt, st);
        directed_rows.push_back(row);
    endtask

    function automatic key_t pick_key(bit narrow);
        int   sel;
        key_t held;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return INVALID_KEY;
        if (sel == 1)
            return $urandom_range(0, 1) ? key_t'(0) : INVALID_KEY - 1;
        if (shadow_count > 0 && sel < 8)
        begin
            held = shadow_keys[$urandom_range(0, shadow_count - 1)];
            // neighbours of a held key probe the rank boundary
            if (sel == 6)
                held = held - 1;
            if (sel == 7)
                held = held + 1;
            return held;
        end
        if (narrow)
            return key_t'($urandom_range(0, 47)) << (4 * $urandom_range(0, 7));
        return key_t'($urandom);
    endfunction

    function automatic opcode_t pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling)
            return (r < 85) ? OP_INSERT : (r < 95) ? OP_LOOKUP : OP_REMOVE;
        if (r < 38)
            return OP_INSERT;
        if (r < 62)
            return OP_LOOKUP;
        if (r < 99)
            return OP_REMOVE;
        return OP_CLEAR;
    endfunction

    initial
    begin
        table_rsp_t none;
        bit         filling;
        none          = mk_rsp(1'b0, 0, 0, ST_OK);
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.opcode = OP_LOOKUP;
        req_if.key    = '0;
        row_typed     = 1'b0;
        row_want      = none;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        long_hold_req = 1'b0;
        fail_count    = 0;
        rsp_index     = 0;
        shadow_count  = 0;

        // empty table, invalid key, extremes, duplicates, absent keys, clear
        add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 32'h0000_0005, 1'b1, 1'b0, 0, 0, ST_OK);
        add_row(OP_INSERT, INVALID_KEY,   1'b1, 1'b0, 0, 0, ST_INVALID);
        add_row(OP_LOOKUP, INVALID_KEY,   1'b1, 1'b0, 0, 0, ST_INVALID);
        add_row(OP_REMOVE, INVALID_KEY,   1'b1, 1'b0, 0, 0, ST_INVALID);
        add_row(OP_INSERT, 32'h0000_0000, 1'b1, 1'b0, 0, 1, ST_OK);
        add_row(OP_INSERT, 32'hFFFF_FFFE, 1'b1, 1'b0, 1, 2, ST_OK);
        add_row(OP_INSERT, 32'h0000_0000, 1'b1, 1'b1, 0, 2, ST_OK);
        add_row(OP_INSERT, 32'h8000_0000, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_INSERT, 32'h5555_5555, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 32'hFFFF_FFFE, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 32'h5555_5555, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 32'h5555_5555, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_INSERT, INVALID_KEY,   1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, 0, 0, ST_OK);
        add_row(OP_CLEAR,  INVALID_KEY,   1'b1, 1'b0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 0, ST_OK);
        add_row(OP_REMOVE, 32'hFFFF_FFFE, 1'b1, 1'b0, 0, 0, ST_OK);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].key,
                    directed_rows[i].typed, directed_rows[i].want);

        // hold the sender until every response is back
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);

        // random episodes: each starts from a clear, alternately filling
        // past capacity and churning a narrow key space
        for (int ep = 0; ep < 8; ep++)
        begin
            filling = (ep % 2 == 0);
            if (ep == 1)
                long_hold_req = 1'b1;
            if (ep == 4)
            begin
                req_if.valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            if (ep == 6)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            send_op(OP_CLEAR, key_t'($urandom), 1'b0, none);
            for (int n = 0; n < (filling ? 160 : 100); n++)
                send_op(pick_op(filling), pick_key(!filling), 1'b0, none);
        end

        // drain, then allow for the pipeline to settle
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/skt_pkg.sv
hdl/skt_in_if.sv
hdl/skt_out_if.sv
hdl/skt_cell.sv
hdl/skt_row.sv
hdl/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
